### rtl/bd_pkg.sv
// bd_pkg: shared types and constants of the bounded deque.
// Holds operation codes, controller states and the per-cell control word.
// No dependencies.
package bd_pkg;

    localparam int COUNT_W     = 5;
    localparam int LIMIT_W     = 5;
    localparam int OP_W        = 4;
    localparam int MAX_RESULTS = 16;

    localparam logic [COUNT_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT   = 4'd0,
        OP_PUSH_BACK    = 4'd1,
        OP_POP_FRONT    = 4'd2,
        OP_POP_BACK     = 4'd3,
        OP_PEEK_FRONT   = 4'd4,
        OP_PEEK_BACK    = 4'd5,
        OP_REMOVE_FIRST = 4'd6,
        OP_REMOVE_LAST  = 4'd7,
        OP_CONTAINS     = 4'd8,
        OP_CLEAR        = 4'd9,
        OP_DRAIN        = 4'd10
    } op_t;

    typedef enum logic {
        ST_IDLE,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic load_key;
        logic take_right;
        logic take_left;
    } cell_ctl_t;

endpackage

### rtl/bd_cell.sv
// bd_cell: one storage cell of the deque chain.
// Holds one entry, compares it with the key and passes match flags on.
// Depends on bd_pkg.
module bd_cell import bd_pkg::*; #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  aclk,
    input  cell_ctl_t             ctl,
    input  logic                  live,
    input  logic [DATA_WIDTH-1:0] key,
    input  logic [DATA_WIDTH-1:0] left_word,
    input  logic [DATA_WIDTH-1:0] right_word,
    input  logic                  first_in,
    input  logic                  last_in,
    output logic [DATA_WIDTH-1:0] word,
    output logic                  first_out,
    output logic                  last_out
);

    logic [DATA_WIDTH-1:0] word_reg;
    logic [DATA_WIDTH-1:0] word_next;
    logic                  hit;

    assign hit       = live && (word_reg == key);
    assign first_out = first_in || hit;
    assign last_out  = last_in || hit;
    assign word      = word_reg;

    always_comb begin
        word_next = word_reg;
        if (ctl.load_key) begin
            word_next = key;
        end else if (ctl.take_right) begin
            word_next = right_word;
        end else if (ctl.take_left) begin
            word_next = left_word;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

endmodule

### rtl/bounded_deque.sv
// bounded_deque: bounded double-ended queue built as a chain of bd_cell.
// Holds the controller, occupancy, capacity register and result register.
// Depends on bd_pkg and bd_cell.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+---------------------------------------
//  s_      | in        | s_valid / s_ready     | s_op, s_data_in, s_drain_limit
//  m_      | out       | m_valid / m_ready     | m_ok, m_data_out, m_count,
//          |           |                       | m_free_slots, m_last
//  cfg_    | in        | cfg_valid / cfg_ready | cfg_capacity
//
// One item per cycle except drain; a drain of n entries gives one result per
// cycle and closes the input until its last result is loaded into the register.
// Results pass through the result register; a stall on m_ready holds it and
// the flow, and the next item is taken in the cycle that the waiting result is taken.
// Synchronous reset empties the deque and sets capacity to 16; entry
// storage is not cleared. cfg_ready is always high.
module bounded_deque import bd_pkg::*; #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [OP_W-1:0]       s_op,
    input  logic [DATA_WIDTH-1:0] s_data_in,
    input  logic [LIMIT_W-1:0]    s_drain_limit,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_ok,
    output logic [DATA_WIDTH-1:0] m_data_out,
    output logic [COUNT_W-1:0]    m_count,
    output logic [COUNT_W-1:0]    m_free_slots,
    output logic                  m_last,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [COUNT_W-1:0]    cfg_capacity
);

    localparam int OW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);
    localparam int CW = (OW > COUNT_W) ? OW : COUNT_W;

    state_t                state_reg, state_next;
    logic [OW-1:0]         occ_reg, occ_next;
    logic [COUNT_W-1:0]    remain_reg, remain_next;
    logic [COUNT_W-1:0]    cap_reg;

    logic                  m_valid_reg;
    logic                  m_ok_reg;
    logic [DATA_WIDTH-1:0] m_data_reg;
    logic [COUNT_W-1:0]    m_count_reg;
    logic [COUNT_W-1:0]    m_free_reg;
    logic                  m_last_reg;

    cell_ctl_t             cell_ctl   [DEPTH];
    logic [DATA_WIDTH-1:0] word       [DEPTH];
    logic [DATA_WIDTH-1:0] left_word  [DEPTH];
    logic [DATA_WIDTH-1:0] right_word [DEPTH];
    logic [DEPTH-1:0]      live;
    logic [DEPTH:0]        first_chain;
    logic [DEPTH:0]        last_chain;

    op_t                   op;
    logic                  out_free;
    logic                  accept;
    logic                  step;
    logic [CW-1:0]         cap_w;
    logic [CW-1:0]         occ_w;
    logic [CW-1:0]         occn_w;
    logic [CW-1:0]         free_w;
    logic [CW-1:0]         lim_w;
    logic [CW-1:0]         part_n;
    logic [CW-1:0]         drain_n;
    logic                  can_push;
    logic                  not_empty;
    logic                  found;
    logic [IW-1:0]         back_idx;

    logic                  res_load;
    logic                  res_ok;
    logic [DATA_WIDTH-1:0] res_data;
    logic                  res_last;

    assign first_chain[0]     = 1'b0;
    assign last_chain[DEPTH]  = 1'b0;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        assign live[i] = OW'(i) < occ_reg;

        if (i == 0) begin : g_head
            assign left_word[i] = '0;
        end else begin : g_body
            assign left_word[i] = word[i-1];
        end

        if (i == DEPTH - 1) begin : g_tail
            assign right_word[i] = '0;
        end else begin : g_inner
            assign right_word[i] = word[i+1];
        end

        bd_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .aclk       (aclk),
            .ctl        (cell_ctl[i]),
            .live       (live[i]),
            .key        (s_data_in),
            .left_word  (left_word[i]),
            .right_word (right_word[i]),
            .first_in   (first_chain[i]),
            .last_in    (last_chain[i+1]),
            .word       (word[i]),
            .first_out  (first_chain[i+1]),
            .last_out   (last_chain[i])
        );
    end

    assign op        = op_t'(s_op);
    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE) && out_free;
    assign accept    = s_valid && s_ready;
    assign step      = (state_reg == ST_DRAIN) && out_free;
    assign cfg_ready = 1'b1;

    assign cap_w     = (CW'(cap_reg) > CW'(DEPTH)) ? CW'(DEPTH) : CW'(cap_reg);
    assign occ_w     = CW'(occ_reg);
    assign can_push  = occ_w < cap_w;
    assign not_empty = occ_reg != '0;
    assign found     = first_chain[DEPTH];
    assign back_idx  = IW'(occ_reg - OW'(1));
    assign lim_w     = CW'(s_drain_limit);
    assign part_n    = (lim_w < occ_w) ? lim_w : occ_w;
    assign drain_n   = (part_n > CW'(MAX_RESULTS)) ? CW'(MAX_RESULTS) : part_n;

    assign occn_w    = CW'(occ_next);
    assign free_w    = (cap_w > occn_w) ? (cap_w - occn_w) : '0;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && op == OP_DRAIN && drain_n > CW'(1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (step && remain_reg == COUNT_W'(1)) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            cell_ctl[i] = '0;
        end
        res_load    = 1'b0;
        res_ok      = 1'b0;
        res_data    = '0;
        res_last    = 1'b1;
        occ_next    = occ_reg;
        remain_next = remain_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    res_load = 1'b1;
                    case (op)
                        OP_PUSH_FRONT: begin
                            if (can_push) begin
                                res_ok   = 1'b1;
                                occ_next = occ_reg + OW'(1);
                                for (int i = 0; i < DEPTH; i++) begin
                                    cell_ctl[i].load_key  = (i == 0);
                                    cell_ctl[i].take_left = (i != 0);
                                end
                            end
                        end
                        OP_PUSH_BACK: begin
                            if (can_push) begin
                                res_ok   = 1'b1;
                                occ_next = occ_reg + OW'(1);
                                for (int i = 0; i < DEPTH; i++) begin
                                    cell_ctl[i].load_key = (OW'(i) == occ_reg);
                                end
                            end
                        end
                        OP_POP_FRONT: begin
                            if (not_empty) begin
                                res_ok   = 1'b1;
                                res_data = word[0];
                                occ_next = occ_reg - OW'(1);
                                for (int i = 0; i < DEPTH; i++) begin
                                    cell_ctl[i].take_right = 1'b1;
                                end
                            end
                        end
                        OP_POP_BACK: begin
                            if (not_empty) begin
                                res_ok   = 1'b1;
                                res_data = word[back_idx];
                                occ_next = occ_reg - OW'(1);
                            end
                        end
                        OP_PEEK_FRONT: begin
                            if (not_empty) begin
                                res_ok   = 1'b1;
                                res_data = word[0];
                            end
                        end
                        OP_PEEK_BACK: begin
                            if (not_empty) begin
                                res_ok   = 1'b1;
                                res_data = word[back_idx];
                            end
                        end
                        OP_REMOVE_FIRST: begin
                            if (found) begin
                                res_ok   = 1'b1;
                                occ_next = occ_reg - OW'(1);
                                for (int i = 0; i < DEPTH; i++) begin
                                    cell_ctl[i].take_right = first_chain[i+1];
                                end
                            end
                        end
                        OP_REMOVE_LAST: begin
                            if (found) begin
                                res_ok   = 1'b1;
                                occ_next = occ_reg - OW'(1);
                                for (int i = 0; i < DEPTH; i++) begin
                                    cell_ctl[i].take_right = !last_chain[i+1];
                                end
                            end
                        end
                        OP_CONTAINS: begin
                            res_ok = found;
                        end
                        OP_CLEAR: begin
                            res_ok   = 1'b1;
                            occ_next = '0;
                        end
                        OP_DRAIN: begin
                            if (drain_n != '0) begin
                                res_ok      = 1'b1;
                                res_data    = word[0];
                                res_last    = (drain_n == CW'(1));
                                occ_next    = occ_reg - OW'(1);
                                remain_next = COUNT_W'(drain_n - CW'(1));
                                for (int i = 0; i < DEPTH; i++) begin
                                    cell_ctl[i].take_right = 1'b1;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_DRAIN: begin
                if (step) begin
                    res_load    = 1'b1;
                    res_ok      = 1'b1;
                    res_data    = word[0];
                    res_last    = (remain_reg == COUNT_W'(1));
                    occ_next    = occ_reg - OW'(1);
                    remain_next = remain_reg - COUNT_W'(1);
                    for (int i = 0; i < DEPTH; i++) begin
                        cell_ctl[i].take_right = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            occ_reg     <= '0;
            remain_reg  <= '0;
            cap_reg     <= CAP_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            occ_reg    <= occ_next;
            remain_reg <= remain_next;
            if (cfg_valid) begin
                cap_reg <= cfg_capacity;
            end
            if (res_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            m_ok_reg    <= res_ok;
            m_data_reg  <= res_data;
            m_count_reg <= COUNT_W'(occn_w);
            m_free_reg  <= COUNT_W'(free_w);
            m_last_reg  <= res_last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_ok         = m_ok_reg;
    assign m_data_out   = m_data_reg;
    assign m_count      = m_count_reg;
    assign m_free_slots = m_free_reg;
    assign m_last       = m_last_reg;

endmodule

### rtl/bd_checker.sv
// bd_checker: port-level assertions for bounded_deque, bound to the top level.
// Watches the input and result channels over time.
// Depends on bd_pkg and bounded_deque.
module bd_checker import bd_pkg::*; #(
    parameter int DATA_WIDTH = 32
) (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic                  m_ok,
    input logic [DATA_WIDTH-1:0] m_data_out,
    input logic                  m_last
);

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ok |-> m_data_out == '0)
        else $error("failed item carries a non-zero word");

    a_drain_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> !s_ready)
        else $error("input taken while a drain is still running");

    a_drain_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=> m_valid)
        else $error("drain stopped before its final item");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data_out) && $stable(m_last))
        else $error("stalled item changed");

endmodule

bind bounded_deque bd_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_bd_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_ok       (m_ok),
    .m_data_out (m_data_out),
    .m_last     (m_last)
);

### verif/bounded_deque_test.sv
`timescale 1ns / 100ps
// bounded_deque_test: self-checking testbench of the bounded deque.
// It predicts every result and compares it with the block's output.
// Depends on bd_pkg and bounded_deque.
module bounded_deque_test;
    import bd_pkg::*;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;

    typedef struct {
        logic              ok;
        logic [DATA_W-1:0] word;
        logic [COUNT_W-1:0] count;
        logic [COUNT_W-1:0] free_slots;
        logic              last;
    } deque_result_t;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [OP_W-1:0]     s_op;
    logic [DATA_W-1:0]   s_data_in;
    logic [LIMIT_W-1:0]  s_drain_limit;
    logic                m_valid;
    logic                m_ready;
    logic                m_ok;
    logic [DATA_W-1:0]   m_data_out;
    logic [COUNT_W-1:0]  m_count;
    logic [COUNT_W-1:0]  m_free_slots;
    logic                m_last;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [COUNT_W-1:0]  cfg_capacity;

    logic [DATA_W-1:0]   held_words[$];
    logic [COUNT_W-1:0]  capacity_reg;
    deque_result_t       pending_results[$];
    int                  failures;
    int                  send_idle_pct;
    int                  stall_pct;
    int                  hold_cycles;

    bounded_deque #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_W)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_data_in     (s_data_in),
        .s_drain_limit (s_drain_limit),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_ok          (m_ok),
        .m_data_out    (m_data_out),
        .m_count       (m_count),
        .m_free_slots  (m_free_slots),
        .m_last        (m_last),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_capacity  (cfg_capacity)
    );

    initial begin
        aclk = 1'b0;
    end

    always #1 aclk = ~aclk;

    function automatic void queue_result(logic ok, logic [DATA_W-1:0] word, logic last);
        deque_result_t r;
        int            room;
        room = (capacity_reg > DEPTH) ? DEPTH : capacity_reg;
        r.ok         = ok;
        r.word       = ok ? word : '0;
        r.count      = COUNT_W'(held_words.size());
        r.free_slots = (room > held_words.size()) ? COUNT_W'(room - held_words.size()) : '0;
        r.last       = last;
        pending_results.push_back(r);
    endfunction

    function automatic void apply_operation(logic [OP_W-1:0] op, logic [DATA_W-1:0] word,
                                            logic [LIMIT_W-1:0] lim);
        int                room;
        int                hit;
        int                n;
        logic [DATA_W-1:0] w;
        room = (capacity_reg > DEPTH) ? DEPTH : capacity_reg;
        hit  = -1;
        case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                if (held_words.size() >= room) begin
                    queue_result(1'b0, '0, 1'b1);
                end else begin
                    if (op == OP_PUSH_FRONT)
                        held_words.push_front(word);
                    else
                        held_words.push_back(word);
                    queue_result(1'b1, '0, 1'b1);
                end
            end
            OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK: begin
                if (held_words.size() == 0) begin
                    queue_result(1'b0, '0, 1'b1);
                end else begin
                    if (op == OP_POP_FRONT || op == OP_PEEK_FRONT)
                        w = held_words[0];
                    else
                        w = held_words[held_words.size() - 1];
                    if (op == OP_POP_FRONT)
                        void'(held_words.pop_front());
                    else if (op == OP_POP_BACK)
                        void'(held_words.pop_back());
                    queue_result(1'b1, w, 1'b1);
                end
            end
            OP_REMOVE_FIRST, OP_CONTAINS: begin
                for (int i = 0; i < held_words.size() && hit < 0; i++)
                    if (held_words[i] == word)
                        hit = i;
                if (hit >= 0 && op == OP_REMOVE_FIRST)
                    held_words.delete(hit);
                queue_result(hit >= 0, '0, 1'b1);
            end
            OP_REMOVE_LAST: begin
                for (int i = held_words.size() - 1; i >= 0 && hit < 0; i--)
                    if (held_words[i] == word)
                        hit = i;
                if (hit >= 0)
                    held_words.delete(hit);
                queue_result(hit >= 0, '0, 1'b1);
            end
            OP_CLEAR: begin
                held_words.delete();
                queue_result(1'b1, '0, 1'b1);
            end
            OP_DRAIN: begin
                n = lim;
                if (n > held_words.size())
                    n = held_words.size();
                if (n > MAX_RESULTS)
                    n = MAX_RESULTS;
                if (n == 0)
                    queue_result(1'b0, '0, 1'b1);
                for (int i = 0; i < n; i++) begin
                    w = held_words.pop_front();
                    queue_result(1'b1, w, i == n - 1);
                end
            end
            default: begin
                queue_result(1'b0, '0, 1'b1);
            end
        endcase
    endfunction

    function automatic void check_field(string name, logic [DATA_W-1:0] want,
                                        logic [DATA_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            failures++;
        end
    endfunction

    // Compare every accepted result with the oldest prediction.
    initial begin
        deque_result_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result with none expected: ok %0b data %0h count %0d",
                           m_ok, m_data_out, m_count);
                    failures++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("ok", DATA_W'(want.ok), DATA_W'(m_ok));
                    check_field("data_out", want.word, m_data_out);
                    check_field("count", DATA_W'(want.count), DATA_W'(m_count));
                    check_field("free_slots", DATA_W'(want.free_slots),
                                DATA_W'(m_free_slots));
                    check_field("last", DATA_W'(want.last), DATA_W'(m_last));
                end
            end
        end
    end

    // Result side: random stalls, or a long hold when one is requested.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_ready <= 1'b0;
                hold_cycles--;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    task automatic send_op(logic [OP_W-1:0] op, logic [DATA_W-1:0] word = '0,
                           logic [LIMIT_W-1:0] lim = '0);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_op          <= op;
        s_data_in     <= word;
        s_drain_limit <= lim;
        do
            @(posedge aclk);
        while (!s_ready);
        apply_operation(op, word, lim);
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_capacity(logic [COUNT_W-1:0] value);
        wait_idle();
        @(negedge aclk);
        cfg_valid    <= 1'b1;
        cfg_capacity <= value;
        do
            @(posedge aclk);
        while (!cfg_ready);
        capacity_reg = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [DATA_W-1:0] pick_word(bit prefer_held);
        if (prefer_held && held_words.size() != 0 && $urandom_range(0, 99) < 60)
            return held_words[$urandom_range(0, held_words.size() - 1)];
        if ($urandom_range(0, 99) < 40)
            return DATA_W'($urandom_range(0, 3));
        return $urandom;
    endfunction

    task automatic test_directed_edges();
        send_op(OP_POP_FRONT);
        send_op(OP_POP_BACK);
        send_op(OP_PEEK_FRONT);
        send_op(OP_PEEK_BACK);
        send_op(OP_DRAIN, '0, 5'd5);
        send_op(OP_REMOVE_FIRST, 32'h1234_5678);
        send_op(OP_PUSH_BACK, 32'hFFFF_FFFF);
        send_op(OP_PUSH_FRONT, 32'h0000_0000);
        send_op(OP_PUSH_BACK, 32'hAAAA_AAAA);
        send_op(OP_PUSH_BACK, 32'h5555_5555);
        send_op(OP_PUSH_FRONT, 32'hAAAA_AAAA);
        send_op(OP_PEEK_FRONT);
        send_op(OP_PEEK_BACK);
        send_op(OP_CONTAINS, 32'h0000_0000);
        send_op(OP_CONTAINS, 32'h1234_5678);
        send_op(OP_REMOVE_LAST, 32'hAAAA_AAAA);
        send_op(OP_REMOVE_FIRST, 32'hFFFF_FFFF);
        send_op(OP_REMOVE_LAST, 32'hDEAD_BEEF);
        send_op(OP_W'(OP_DRAIN + 1), 32'hFFFF_FFFF, 5'd31);
        send_op({OP_W{1'b1}}, 32'hFFFF_FFFF);
        send_op(OP_DRAIN, '0, '0);
        send_op(OP_POP_BACK);
        send_op(OP_DRAIN, '0, 5'd31);
        send_op(OP_PUSH_BACK, 32'h8000_0001);
        send_op(OP_CLEAR);
        send_op(OP_CLEAR);
    endtask

    task automatic test_capacity_limits();
        write_capacity(5'd1);
        send_op(OP_PUSH_BACK, 32'h0000_0011);
        send_op(OP_PUSH_FRONT, 32'h0000_0022);
        send_op(OP_POP_FRONT);
        write_capacity(5'd0);
        send_op(OP_PUSH_BACK, 32'h0000_0033);
        send_op(OP_PEEK_BACK);
        write_capacity(5'd31);
        for (int i = 0; i <= DEPTH; i++)
            send_op((i % 2) ? OP_PUSH_FRONT : OP_PUSH_BACK, $urandom);
        write_capacity(5'd4);
        send_op(OP_PUSH_BACK, 32'h0000_0044);
        send_op(OP_POP_BACK);
        send_op(OP_DRAIN, '0, 5'd31);
        write_capacity(CAP_RESET);
    endtask

    task automatic test_random_traffic(int items);
        int                pick;
        logic [OP_W-1:0]   op;
        logic [LIMIT_W-1:0] lim;
        for (int k = 0; k < items; k++) begin
            pick = $urandom_range(0, 99);
            lim  = '0;
            if (pick < 40)
                op = OP_W'(OP_PUSH_FRONT + $urandom_range(0, 1));
            else if (pick < 58)
                op = OP_W'(OP_POP_FRONT + $urandom_range(0, 3));
            else if (pick < 77)
                op = OP_W'(OP_REMOVE_FIRST + $urandom_range(0, 2));
            else if (pick < 90) begin
                op  = OP_DRAIN;
                lim = ($urandom_range(0, 99) < 80) ? LIMIT_W'($urandom_range(0, 6))
                                                   : LIMIT_W'($urandom_range(0, 31));
            end else if (pick < 95)
                op = OP_CLEAR;
            else
                op = OP_W'($urandom_range(OP_DRAIN + 1, (1 << OP_W) - 1));
            send_op(op, pick_word(op >= OP_REMOVE_FIRST), lim);
        end
    endtask

    task automatic test_random_phases();
        logic [COUNT_W-1:0] caps[4];
        int                 idle_set[4];
        int                 stall_set[4];
        caps      = '{CAP_RESET, 5'd3, 5'd9, 5'd31};
        idle_set  = '{0, 60, 0, 30};
        stall_set = '{0, 0, 60, 30};
        for (int p = 0; p < 4; p++) begin
            write_capacity(caps[p]);
            send_idle_pct = idle_set[p];
            stall_pct     = stall_set[p];
            test_random_traffic(60);
        end
    endtask

    task automatic test_output_backpressure();
        send_idle_pct = 0;
        stall_pct     = 0;
        write_capacity(CAP_RESET);
        hold_cycles = 80;
        send_op(OP_CLEAR);
        for (int i = 0; i < 20; i++)
            send_op(OP_PUSH_BACK, $urandom);
        for (int i = 0; i < 10; i++)
            send_op(OP_POP_FRONT);
    endtask

    initial begin
        #500000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_op          = '0;
        s_data_in     = '0;
        s_drain_limit = '0;
        cfg_valid     = 1'b0;
        cfg_capacity  = CAP_RESET;
        failures      = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_cycles   = 0;
        capacity_reg  = CAP_RESET;
        held_words.delete();
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_edges();
        test_capacity_limits();
        test_random_phases();
        test_output_backpressure();

        stall_pct = 0;
        wait_idle();
        repeat (8) @(posedge aclk);
        if (failures == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
